// ===== src/brgc_pkg.sv =====
// Shared types and constants for the bitmap row glyph classifier.
// Used by brgc_cell, brgc_queue and bitmap_row_glyph_classifier; no dependencies.
`timescale 1ns / 1ps

package brgc_pkg;

  // fixed field widths
  localparam int unsigned ROW_W   = 31;
  localparam int unsigned GLYPH_W = 62;
  localparam int unsigned CFG_W   = 5;
  // width compare is done one bit wider than the register so MAX_WIDTH=32 fits
  localparam int unsigned EW      = CFG_W + 1;

  localparam int unsigned MAX_WIDTH_DEF = 31;
  localparam int unsigned MIN_WIDTH     = 3;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd31;

  // glyph codes
  localparam logic [1:0] GLYPH_SPACE = 2'd0;
  localparam logic [1:0] GLYPH_HORIZ = 2'd1;
  localparam logic [1:0] GLYPH_VERT  = 2'd2;
  localparam logic [1:0] GLYPH_JUNCT = 2'd3;

  // output queue
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  // row-wide control, same for every cell
  typedef struct packed {
    logic load;        // a row word is accepted this cycle
    logic clear;       // accepted word ends the picture
    logic held_valid;  // cells hold a row waiting for the row below
    logic first;       // held row is the picture's top row
  } brgc_row_ctl_t;

  // column position of one cell under the current width
  typedef struct packed {
    logic in_use;
    logic at_left;
    logic at_right;
  } brgc_col_pos_t;

  // one result word
  typedef struct packed {
    logic [GLYPH_W-1:0] glyph_row;
    logic               last_of_run;
    logic               picture_end;
  } brgc_word_t;

endpackage

// ===== src/brgc_cell.sv =====
// One column cell: holds the above and held bits of its column and classifies them.
// Depends on brgc_pkg.
`timescale 1ns / 1ps

module brgc_cell import brgc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  brgc_row_ctl_t ctl,
  input  brgc_col_pos_t pos,
  input  logic          row_bit,     // incoming row, already masked to the width
  input  logic          left_held,   // neighbor held bits, masked
  input  logic          right_held,
  output logic          held_out,
  output logic [1:0]    glyph_main,  // glyph of the held row
  output logic [1:0]    glyph_tail   // glyph of the incoming row as bottom row
);

  logic above_r, above_nxt;
  logic held_r, held_nxt;
  logic up_bit, down_bit;

  assign held_out = held_r & pos.in_use;
  assign up_bit   = above_r & pos.in_use;
  // no row below is known when nothing is held (lone row)
  assign down_bit = row_bit & ctl.held_valid;

  // held row classification
  always_comb begin
    if (!pos.in_use) begin
      glyph_main = GLYPH_SPACE;
    end else if (ctl.first) begin
      glyph_main = down_bit ? GLYPH_JUNCT : GLYPH_HORIZ;
    end else if (pos.at_left) begin
      glyph_main = right_held ? GLYPH_JUNCT : GLYPH_VERT;
    end else if (pos.at_right) begin
      glyph_main = left_held ? GLYPH_JUNCT : GLYPH_VERT;
    end else if (!held_out) begin
      glyph_main = GLYPH_SPACE;
    end else if (left_held && right_held && !up_bit && !down_bit) begin
      glyph_main = GLYPH_HORIZ;
    end else if (!left_held && !right_held && up_bit && down_bit) begin
      glyph_main = GLYPH_VERT;
    end else begin
      glyph_main = GLYPH_JUNCT;
    end
  end

  // bottom row: only the held row above matters
  always_comb begin
    if (!pos.in_use) begin
      glyph_tail = GLYPH_SPACE;
    end else begin
      glyph_tail = held_out ? GLYPH_JUNCT : GLYPH_HORIZ;
    end
  end

  // shift the column down by one row on each accepted word; a picture-ending word clears it
  always_comb begin
    above_nxt = above_r;
    held_nxt  = held_r;
    if (ctl.load) begin
      if (ctl.clear) begin
        above_nxt = 1'b0;
        held_nxt  = 1'b0;
      end else begin
        above_nxt = ctl.held_valid ? held_r : 1'b0;
        held_nxt  = row_bit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      above_r <= 1'b0;
      held_r  <= 1'b0;
    end else begin
      above_r <= above_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

// ===== src/brgc_queue.sv =====
// Result word queue: takes up to two words a cycle, hands out one.
// Depends on brgc_pkg.
`timescale 1ns / 1ps

module brgc_queue import brgc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_cnt,   // words written this cycle, 0..2
  input  brgc_word_t push_word0,
  input  brgc_word_t push_word1,
  input  logic       pop,
  output brgc_word_t head_word,
  output logic       head_valid,
  output logic       room2       // space for two words
);

  brgc_word_t       mem_r [QDEPTH];
  logic [QPW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPW-1:0]   wr_ptr_p1;
  logic [QCW-1:0]   count_r, count_nxt;

  assign wr_ptr_p1  = QPW'(wr_ptr_r + 1'b1);
  assign head_word  = mem_r[rd_ptr_r];
  assign head_valid = (count_r != '0);
  assign room2      = (count_r <= QCW'(QDEPTH - 2));

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = QPW'(wr_ptr_r + push_cnt);
    rd_ptr_nxt = pop ? QPW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = QCW'(count_r + QCW'(push_cnt) - QCW'(pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push_word0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wr_ptr_p1] <= push_word1;
    end
  end

  // checks
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCW'(QDEPTH))
    else $error("queue fill above depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push_cnt == 2'd2) |-> (count_r <= QCW'(QDEPTH - 2)))
    else $error("double push into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("pop from an empty queue");

endmodule

// ===== src/bitmap_row_glyph_classifier.sv =====
// Top level of the bitmap row glyph classifier: column cell chain plus result queue.
// Depends on brgc_pkg, brgc_cell and brgc_queue.
//
//  channel  | ports                                         | word
//  ---------+-----------------------------------------------+-----------------------------
//  in       | in_valid, in_ready, in_row_bits, in_last_row  | one bitmap row
//  out      | out_valid, out_ready, out_glyph_row,          | one glyph row
//           | out_last_of_run, out_picture_end              |
//  cfg      | cfg_wr_en, cfg_wr_data                        | row_width register
//
// One row word is accepted per cycle while in_ready is high; all columns are classified at once
// in the cell row. A final row that follows a held row makes two result words; results are
// registered in the queue and leave in the cycle after acceptance at the earliest.
// Results pass through a four-word queue; in_ready is high while at most two words wait.
// Reset (rst_n low, synchronous) empties the queue, clears the cells, sets row_width to 31.
`timescale 1ns / 1ps

module bitmap_row_glyph_classifier import brgc_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [CFG_W-1:0]   cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [ROW_W-1:0]   in_row_bits,
  input  logic               in_last_row,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [GLYPH_W-1:0] out_glyph_row,
  output logic               out_last_of_run,
  output logic               out_picture_end
);

  logic [CFG_W-1:0]     row_width_r, row_width_nxt;
  logic                 have_held_r, have_held_nxt;
  logic                 held_is_first_r, held_is_first_nxt;
  logic [EW-1:0]        eff_w;
  logic                 in_fire;
  logic                 two_words;
  logic [1:0]           push_cnt;
  brgc_row_ctl_t        row_ctl;
  brgc_col_pos_t        col_pos [MAX_WIDTH];
  logic [MAX_WIDTH-1:0] row_bit_v;
  logic [MAX_WIDTH-1:0] held_v;
  logic [1:0]           gm_v [MAX_WIDTH];
  logic [1:0]           gt_v [MAX_WIDTH];
  logic [GLYPH_W-1:0]   glyph_main_row;
  logic [GLYPH_W-1:0]   glyph_tail_row;
  brgc_word_t           word0, word1, head_word;
  logic                 room2;

  // config register
  assign row_width_nxt = cfg_wr_en ? cfg_wr_data : row_width_r;

  // width in use, clamped to MIN_WIDTH..MAX_WIDTH
  always_comb begin
    if (EW'(row_width_r) < EW'(MIN_WIDTH)) begin
      eff_w = EW'(MIN_WIDTH);
    end else if (EW'(row_width_r) > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(row_width_r);
    end
  end

  // handshake and result count
  assign in_ready  = room2;
  assign in_fire   = in_valid & in_ready;
  assign two_words = have_held_r & in_last_row;

  always_comb begin
    if (!in_fire) begin
      push_cnt = 2'd0;
    end else if (two_words) begin
      push_cnt = 2'd2;
    end else if (!have_held_r && !in_last_row) begin
      push_cnt = 2'd0;
    end else begin
      push_cnt = 2'd1;
    end
  end

  // picture flags
  always_comb begin
    have_held_nxt     = have_held_r;
    held_is_first_nxt = held_is_first_r;
    if (in_fire) begin
      if (in_last_row) begin
        have_held_nxt     = 1'b0;
        held_is_first_nxt = 1'b1;
      end else begin
        have_held_nxt     = 1'b1;
        held_is_first_nxt = !have_held_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r     <= CFG_RESET;
      have_held_r     <= 1'b0;
      held_is_first_r <= 1'b1;
    end else begin
      row_width_r     <= row_width_nxt;
      have_held_r     <= have_held_nxt;
      held_is_first_r <= held_is_first_nxt;
    end
  end

  assign row_ctl.load       = in_fire;
  assign row_ctl.clear      = in_last_row;
  assign row_ctl.held_valid = have_held_r;
  assign row_ctl.first      = held_is_first_r;

  // cell row, one cell per column
  for (genvar j = 0; j < MAX_WIDTH; j++) begin : g_col
    logic left_n, right_n;

    assign col_pos[j].in_use   = (EW'(j) < eff_w);
    assign col_pos[j].at_left  = (j == 0);
    assign col_pos[j].at_right = (EW'(j + 1) == eff_w);

    if (j < ROW_W) begin : g_in
      assign row_bit_v[j] = in_row_bits[j] & col_pos[j].in_use;
    end else begin : g_pad
      assign row_bit_v[j] = 1'b0;
    end

    if (j == 0) begin : g_l0
      assign left_n = 1'b0;
    end else begin : g_l
      assign left_n = held_v[j-1];
    end

    if (j == MAX_WIDTH - 1) begin : g_r0
      assign right_n = 1'b0;
    end else begin : g_r
      assign right_n = held_v[j+1];
    end

    brgc_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (row_ctl),
      .pos        (col_pos[j]),
      .row_bit    (row_bit_v[j]),
      .left_held  (left_n),
      .right_held (right_n),
      .held_out   (held_v[j]),
      .glyph_main (gm_v[j]),
      .glyph_tail (gt_v[j])
    );
  end

  // pack glyphs into the output field
  for (genvar k = 0; k < ROW_W; k++) begin : g_pack
    if (k < MAX_WIDTH) begin : g_used
      assign glyph_main_row[2*k +: 2] = gm_v[k];
      assign glyph_tail_row[2*k +: 2] = gt_v[k];
    end else begin : g_zero
      assign glyph_main_row[2*k +: 2] = GLYPH_SPACE;
      assign glyph_tail_row[2*k +: 2] = GLYPH_SPACE;
    end
  end

  // result words
  assign word0.glyph_row   = glyph_main_row;
  assign word0.last_of_run = !two_words;
  assign word0.picture_end = !have_held_r & in_last_row;
  assign word1.glyph_row   = glyph_tail_row;
  assign word1.last_of_run = 1'b1;
  assign word1.picture_end = 1'b1;

  brgc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cnt   (push_cnt),
    .push_word0 (word0),
    .push_word1 (word1),
    .pop        (out_valid & out_ready),
    .head_word  (head_word),
    .head_valid (out_valid),
    .room2      (room2)
  );

  assign out_glyph_row   = head_word.glyph_row;
  assign out_last_of_run = head_word.last_of_run;
  assign out_picture_end = head_word.picture_end;

  // checks
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_last_row) |=> (!have_held_r && held_is_first_r))
    else $error("picture state not cleared after last row");
  a_first_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !have_held_r |-> held_is_first_r)
    else $error("empty cell row not marked as picture top");
  a_start_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_last_row && !have_held_r) |=> (have_held_r && held_is_first_r))
    else $error("first row of a picture not held as top row");

endmodule
